[sv/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/srtc_pkg.sv]
// Package: beat types, phase encoding and helper functions for the serial RTC core.
`timescale 1ns / 1ps
`default_nettype none

package srtc_pkg;

	localparam int MAX_TRANSFER_BITS_DEF = 56;

	localparam logic [3:0] MAGIC_NIBBLE  = 4'b0110;
	localparam logic [7:0] CONTROL_RESET = 8'b0100_0000;
	localparam logic [7:0] CONTROL_WMASK = 8'h95;

	// Phase codes as seen on the result beat
	localparam logic [2:0] PHASE_CODE_START1  = 3'd0;
	localparam logic [2:0] PHASE_CODE_START2  = 3'd1;
	localparam logic [2:0] PHASE_CODE_COMMAND = 3'd2;
	localparam logic [2:0] PHASE_CODE_READ    = 3'd3;
	localparam logic [2:0] PHASE_CODE_WRITE   = 3'd4;

	// Command codes
	localparam logic [2:0] CMD_RESET   = 3'd0;
	localparam logic [2:0] CMD_CONTROL = 3'd1;
	localparam logic [2:0] CMD_DATE    = 3'd2;
	localparam logic [2:0] CMD_TIME    = 3'd3;
	localparam logic [2:0] CMD_ALARM1  = 3'd4;
	localparam logic [2:0] CMD_ALARM2  = 3'd5;
	localparam logic [2:0] CMD_IRQ     = 3'd6;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	typedef enum logic [4:0] {
		PH_START1  = 5'b00001,
		PH_START2  = 5'b00010,
		PH_COMMAND = 5'b00100,
		PH_READ    = 5'b01000,
		PH_WRITE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       sck;
		logic       sio;
		logic       cs;
		logic [6:0] year_in_century;
		logic [3:0] month_number;
		logic [4:0] day_of_month;
		logic [2:0] weekday_number;
		logic [4:0] hour_number;
		logic [5:0] minute_number;
		logic [5:0] second_number;
	} cmd_beat_t;

	typedef struct packed {
		logic       drive_valid;
		logic       drive_bit;
		logic [7:0] control_value;
		logic [2:0] phase_code;
		logic       protocol_error;
	} rsp_beat_t;

	// Transfer length in bits for each command
	function automatic logic [5:0] cmd_length(input logic [2:0] cmd);
		logic [5:0] len;
		unique case (cmd)
			CMD_RESET:   len = 6'd8;
			CMD_CONTROL: len = 6'd8;
			CMD_DATE:    len = 6'd56;
			CMD_TIME:    len = 6'd24;
			CMD_ALARM1:  len = 6'd24;
			CMD_ALARM2:  len = 6'd24;
			CMD_IRQ:     len = 6'd0;
			CMD_UNUSED:  len = 6'd0;
			default:     len = 6'd0;
		endcase
		return len;
	endfunction

	// Saturate at 99 and convert to two BCD digits
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [6:0] sat;
		logic [3:0] tens;
		logic [6:0] ones;
		sat  = (v > 7'd99) ? 7'd99 : v;
		tens = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (sat >= 7'(i * 10))
				tens = tens + 4'd1;
		end
		ones = sat - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[7 - i] = b[i];
		return r;
	endfunction

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_START1:  code = PHASE_CODE_START1;
			PH_START2:  code = PHASE_CODE_START2;
			PH_COMMAND: code = PHASE_CODE_COMMAND;
			PH_READ:    code = PHASE_CODE_READ;
			PH_WRITE:   code = PHASE_CODE_WRITE;
			default:    code = PHASE_CODE_START1;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

[sv/serial_rtc_command_interface_core.sv]
// Top level: serial RTC command interface, one GPIO write beat in, one status beat out.
// Usage:
//  - cmd channel (cmd_valid/cmd_ready/cmd): one beat per GPIO write, carrying the
//    SCK, SIO and CS levels plus the current calendar fields in binary.
//  - rsp channel (rsp_valid/rsp_ready/rsp): exactly one beat per cmd beat, in order,
//    carrying the read bit driven onto SIO (if any), the control register, the
//    protocol phase after the write, and a protocol error flag.
//  - Latency: the rsp beat is valid the cycle after its cmd beat is accepted.
//  - Throughput: one beat per cycle unless stalled. All protocol state (phase, shift
//    register, bit counter, latched bit, command, control register) updates in the
//    cycle the cmd beat is taken; the single output register holds the status beat.
//  - Stall: while a status beat waits on rsp_ready low, cmd_ready is low; cmd_ready
//    follows rsp_ready so a beat may enter in the same cycle the held one leaves.
//  - Reset (arst_n low, async): phase start1, shift register and bit counter zero,
//    command code unused, control register 0x40, no rsp pending.
`timescale 1ns / 1ps
`default_nettype none

module serial_rtc_command_interface_core #(
	parameter int MAX_TRANSFER_BITS = srtc_pkg::MAX_TRANSFER_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output      logic              cmd_ready,
	input  wire srtc_pkg::cmd_beat_t cmd,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      srtc_pkg::rsp_beat_t rsp
);

	localparam int         IDX_W    = $clog2(MAX_TRANSFER_BITS);
	localparam logic [6:0] MAX_BITS = 7'(MAX_TRANSFER_BITS);

	// Protocol state
	srtc_pkg::phase_t               phase_q, phase_n;
	logic [MAX_TRANSFER_BITS-1:0]   shift_q, shift_n;
	logic [5:0]                     bitpos_q, bitpos_n;
	logic                           latch_q, latch_n;
	logic [2:0]                     cmd_q, cmd_n;
	logic [7:0]                     ctrl_q, ctrl_n;

	// Output register
	logic                           rsp_valid_q;
	srtc_pkg::rsp_beat_t            rsp_q;

	logic                           cmd_acc;
	logic                           drv_valid, drv_bit, err;

	// Helper values
	logic                           pos_in_range;
	logic [IDX_W-1:0]               pos_idx;
	logic [5:0]                     bitpos_inc;
	logic [MAX_TRANSFER_BITS-1:0]   shift_ins;
	logic [5:0]                     cur_len;
	logic [7:0]                     cmd_byte;
	logic [7:0]                     dec_byte;
	logic [2:0]                     dec_cmd;
	logic [63:0]                    date_word;
	logic [63:0]                    time_word;
	logic [63:0]                    ctrl_word;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Shift-in helpers: bits at or past the transfer limit are dropped,
	// the bit counter saturates at 63.
	assign pos_in_range = ({1'b0, bitpos_q} < MAX_BITS);
	assign pos_idx      = bitpos_q[IDX_W-1:0];
	assign bitpos_inc   = (bitpos_q == 6'd63) ? bitpos_q : bitpos_q + 6'd1;
	assign cur_len      = srtc_pkg::cmd_length(cmd_q);

	always_comb begin
		shift_ins = shift_q;
		if (pos_in_range)
			shift_ins[pos_idx] = latch_q;
	end

	// Command byte decode: the magic nibble belongs in the high bits, otherwise
	// the byte was sent in the other bit order.
	assign cmd_byte = shift_ins[7:0];
	assign dec_byte = (cmd_byte[7:4] == srtc_pkg::MAGIC_NIBBLE) ? cmd_byte
		: srtc_pkg::reverse8(cmd_byte);
	assign dec_cmd  = dec_byte[3:1];

	// Read images
	assign date_word = {8'h00,
		srtc_pkg::to_bcd({1'b0, cmd.second_number}),
		srtc_pkg::to_bcd({1'b0, cmd.minute_number}),
		srtc_pkg::to_bcd({2'b00, cmd.hour_number}),
		srtc_pkg::to_bcd({4'b0000, cmd.weekday_number}),
		srtc_pkg::to_bcd({2'b00, cmd.day_of_month}),
		srtc_pkg::to_bcd({3'b000, cmd.month_number}),
		srtc_pkg::to_bcd(cmd.year_in_century)};
	assign time_word = {40'h0,
		srtc_pkg::to_bcd({1'b0, cmd.second_number}),
		srtc_pkg::to_bcd({1'b0, cmd.minute_number}),
		srtc_pkg::to_bcd({2'b00, cmd.hour_number})};
	assign ctrl_word = {56'h0, ctrl_q};

	always_comb begin
		phase_n   = phase_q;
		shift_n   = shift_q;
		bitpos_n  = bitpos_q;
		latch_n   = latch_q;
		cmd_n     = cmd_q;
		ctrl_n    = ctrl_q;
		drv_valid = 1'b0;
		drv_bit   = 1'b0;
		err       = 1'b0;
		unique case (phase_q)
			srtc_pkg::PH_START1: begin
				if (!cmd.cs && cmd.sck) begin
					shift_n  = '0;
					bitpos_n = '0;
					phase_n  = srtc_pkg::PH_START2;
				end else begin
					err = 1'b1;
				end
			end
			srtc_pkg::PH_START2: begin
				if (cmd.cs && cmd.sck)
					phase_n = srtc_pkg::PH_COMMAND;
			end
			srtc_pkg::PH_COMMAND: begin
				if (!cmd.cs) begin
					err = 1'b1;
				end else if (!cmd.sck) begin
					latch_n = cmd.sio;
				end else begin
					shift_n  = shift_ins;
					bitpos_n = bitpos_inc;
					if (bitpos_inc == 6'd8) begin
						if (cmd_byte[7:4] != srtc_pkg::MAGIC_NIBBLE &&
							cmd_byte[3:0] != srtc_pkg::MAGIC_NIBBLE)
							err = 1'b1;
						phase_n  = dec_byte[0] ? srtc_pkg::PH_READ : srtc_pkg::PH_WRITE;
						cmd_n    = dec_cmd;
						shift_n  = '0;
						bitpos_n = '0;
						unique case (dec_cmd)
							srtc_pkg::CMD_RESET: begin
								ctrl_n  = '0;
								phase_n = srtc_pkg::PH_START1;
							end
							srtc_pkg::CMD_CONTROL: begin
								if (dec_byte[0])
									shift_n = ctrl_word[MAX_TRANSFER_BITS-1:0];
							end
							srtc_pkg::CMD_DATE: begin
								if (dec_byte[0])
									shift_n = date_word[MAX_TRANSFER_BITS-1:0];
							end
							srtc_pkg::CMD_TIME: begin
								if (dec_byte[0])
									shift_n = time_word[MAX_TRANSFER_BITS-1:0];
							end
							default: begin
								err = 1'b1;
							end
						endcase
					end
				end
			end
			srtc_pkg::PH_READ: begin
				if (!cmd.cs) begin
					phase_n = srtc_pkg::PH_START1;
					if (bitpos_q != cur_len)
						err = 1'b1;
				end else if (cmd.sck) begin
					drv_valid = 1'b1;
					drv_bit   = pos_in_range ? shift_q[pos_idx] : 1'b0;
					latch_n   = drv_bit;
					bitpos_n  = bitpos_inc;
					if (bitpos_inc == cur_len)
						phase_n = srtc_pkg::PH_START1;
				end
			end
			srtc_pkg::PH_WRITE: begin
				if (!cmd.cs) begin
					phase_n = srtc_pkg::PH_START1;
					if (bitpos_q != cur_len)
						err = 1'b1;
				end else if (!cmd.sck) begin
					latch_n = cmd.sio;
				end else begin
					shift_n  = shift_ins;
					bitpos_n = bitpos_inc;
					if (bitpos_inc >= cur_len) begin
						phase_n = srtc_pkg::PH_START1;
						if (cmd_q == srtc_pkg::CMD_CONTROL)
							ctrl_n = shift_ins[7:0] & ~srtc_pkg::CONTROL_WMASK;
						else
							err = 1'b1;
					end
				end
			end
			default: begin
				phase_n = srtc_pkg::PH_START1;
			end
		endcase
	end

	// State updates on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= srtc_pkg::PH_START1;
			shift_q  <= '0;
			bitpos_q <= '0;
			latch_q  <= 1'b0;
			cmd_q    <= srtc_pkg::CMD_UNUSED;
			ctrl_q   <= srtc_pkg::CONTROL_RESET;
		end else if (cmd_acc) begin
			phase_q  <= phase_n;
			shift_q  <= shift_n;
			bitpos_q <= bitpos_n;
			latch_q  <= latch_n;
			cmd_q    <= cmd_n;
			ctrl_q   <= ctrl_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			rsp_q.drive_valid    <= drv_valid;
			rsp_q.drive_bit      <= drv_bit;
			rsp_q.control_value  <= ctrl_n;
			rsp_q.phase_code     <= srtc_pkg::phase_code(phase_n);
			rsp_q.protocol_error <= err;
		end
	end

endmodule

`default_nettype wire

[sv/srtc_checker.sv]
// Port-level checker for the serial RTC core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srtc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire srtc_pkg::cmd_beat_t cmd,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire srtc_pkg::rsp_beat_t rsp
);

	logic cmd_fire;
	logic rsp_stall;

	assign cmd_fire  = cmd_valid && cmd_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")
	`ASSERT_NEXT(a_one_rsp_per_cmd, clk, arst_n, cmd_fire, rsp_valid, "accepted beat produced no rsp beat")
	`ASSERT_SAME(a_bit_needs_drive, clk, arst_n, rsp_valid && rsp.drive_bit, rsp.drive_valid, "read bit set without drive")
	`ASSERT_SAME(a_drive_phase, clk, arst_n, rsp_valid && rsp.drive_valid, rsp.phase_code == srtc_pkg::PHASE_CODE_READ || rsp.phase_code == srtc_pkg::PHASE_CODE_START1, "drive outside a read")
	`ASSERT_SAME(a_ctrl_mask, clk, arst_n, rsp_valid, (rsp.control_value & srtc_pkg::CONTROL_WMASK) == 8'h00, "masked control bits set")

endmodule

bind serial_rtc_command_interface_core srtc_checker u_srtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

[dv/srtc_status_checker.sv]
// Status beat checker for the serial RTC core: predicts each status beat and compares.
`timescale 1ns / 1ps
`default_nettype none

module srtc_status_checker #(
	parameter int MAX_BITS = srtc_pkg::MAX_TRANSFER_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire logic                cmd_ready,
	input  wire srtc_pkg::cmd_beat_t cmd,
	input  wire logic                rsp_valid,
	input  wire logic                rsp_ready,
	input  wire srtc_pkg::rsp_beat_t rsp,
	output int                       fail_count,
	output int                       pending,
	output int                       checked,
	output int                       bits_driven
);
	import srtc_pkg::*;

	// bits at or above MAX_BITS never land in the shift register
	localparam logic [63:0] KEEP_MASK = (64'd1 << MAX_BITS) - 64'd1;

	logic [2:0]  phase_q;
	logic [63:0] shreg;
	logic [5:0]  bitpos;
	logic        latch_bit;
	logic [2:0]  active_cmd;
	logic [7:0]  control_q;
	rsp_beat_t   status_q[$];

	function automatic logic [63:0] bcd8(input int unsigned v);
		int unsigned s;
		s = (v > 99) ? 99 : v;
		return 64'({4'(s / 10), 4'(s % 10)});
	endfunction

	task automatic shift_latched();
		if (bitpos < MAX_BITS)
			shreg = (shreg | (64'(latch_bit) << bitpos)) & KEEP_MASK;
		if (bitpos < 6'd63)
			bitpos = bitpos + 6'd1;
	endtask

	task automatic predict_status(input cmd_beat_t g, output rsp_beat_t s);
		logic [5:0] len;
		logic [7:0] cbyte;
		logic [7:0] flipped;
		logic       dv;
		logic       db;
		logic       err;
		dv = 1'b0;
		db = 1'b0;
		err = 1'b0;
		case (active_cmd)
			CMD_RESET, CMD_CONTROL:           len = 6'd8;
			CMD_DATE:                         len = 6'd56;
			CMD_TIME, CMD_ALARM1, CMD_ALARM2: len = 6'd24;
			default:                          len = 6'd0;
		endcase
		case (phase_q)
			PHASE_CODE_START1: begin
				if (!g.cs && g.sck) begin
					shreg = '0;
					bitpos = '0;
					phase_q = PHASE_CODE_START2;
				end else begin
					err = 1'b1;
				end
			end
			PHASE_CODE_START2: begin
				if (g.cs && g.sck)
					phase_q = PHASE_CODE_COMMAND;
			end
			PHASE_CODE_COMMAND: begin
				if (!g.cs) begin
					err = 1'b1;
				end else if (!g.sck) begin
					latch_bit = g.sio;
				end else begin
					shift_latched();
					if (bitpos == 6'd8) begin
						cbyte = shreg[7:0];
						if (cbyte[7:4] != MAGIC_NIBBLE) begin
							if (cbyte[3:0] != MAGIC_NIBBLE)
								err = 1'b1;
							flipped = {<<{cbyte}};
							cbyte = flipped;
						end
						phase_q = cbyte[0] ? PHASE_CODE_READ : PHASE_CODE_WRITE;
						active_cmd = cbyte[3:1];
						shreg = '0;
						bitpos = '0;
						case (active_cmd)
							CMD_RESET: begin
								control_q = '0;
								phase_q = PHASE_CODE_START1;
							end
							CMD_CONTROL: begin
								if (phase_q == PHASE_CODE_READ)
									shreg = 64'(control_q);
							end
							CMD_DATE: begin
								if (phase_q == PHASE_CODE_READ)
									shreg = (bcd8(g.year_in_century)
										| (bcd8(g.month_number) << 8)
										| (bcd8(g.day_of_month) << 16)
										| (bcd8(g.weekday_number) << 24)
										| (bcd8(g.hour_number) << 32)
										| (bcd8(g.minute_number) << 40)
										| (bcd8(g.second_number) << 48)) & KEEP_MASK;
							end
							CMD_TIME: begin
								if (phase_q == PHASE_CODE_READ)
									shreg = bcd8(g.hour_number)
										| (bcd8(g.minute_number) << 8)
										| (bcd8(g.second_number) << 16);
							end
							default: err = 1'b1;
						endcase
					end
				end
			end
			PHASE_CODE_READ: begin
				if (!g.cs) begin
					phase_q = PHASE_CODE_START1;
					if (bitpos != len)
						err = 1'b1;
				end else if (g.sck) begin
					db = (bitpos < MAX_BITS) ? shreg[bitpos] : 1'b0;
					latch_bit = db;
					dv = 1'b1;
					if (bitpos < 6'd63)
						bitpos = bitpos + 6'd1;
					if (bitpos == len)
						phase_q = PHASE_CODE_START1;
				end
			end
			PHASE_CODE_WRITE: begin
				if (!g.cs) begin
					phase_q = PHASE_CODE_START1;
					if (bitpos != len)
						err = 1'b1;
				end else if (!g.sck) begin
					latch_bit = g.sio;
				end else begin
					shift_latched();
					if (bitpos >= len) begin
						phase_q = PHASE_CODE_START1;
						if (active_cmd == CMD_CONTROL)
							control_q = shreg[7:0] & ~CONTROL_WMASK;
						else
							err = 1'b1;
					end
				end
			end
			default: phase_q = PHASE_CODE_START1;
		endcase
		s.drive_valid = dv;
		s.drive_bit = db;
		s.control_value = control_q;
		s.phase_code = phase_q;
		s.protocol_error = err;
	endtask

	task automatic note_diff(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_beat_t want;
		rsp_beat_t got;
		if (!arst_n) begin
			phase_q = PHASE_CODE_START1;
			shreg = '0;
			bitpos = '0;
			latch_bit = 1'b0;
			active_cmd = CMD_UNUSED;
			control_q = CONTROL_RESET;
			status_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			bits_driven = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				predict_status(cmd, want);
				status_q.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				got = rsp;
				checked++;
				if (got.drive_valid === 1'b1)
					bits_driven++;
				if (status_q.size() == 0) begin
					$display("%0t: status beat %h with none expected", $time, got);
					fail_count++;
				end else begin
					want = status_q.pop_front();
					note_diff("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
					note_diff("drive_bit", 8'(want.drive_bit), 8'(got.drive_bit));
					note_diff("control_value", want.control_value, got.control_value);
					note_diff("phase_code", 8'(want.phase_code), 8'(got.phase_code));
					note_diff("protocol_error", 8'(want.protocol_error),
						8'(got.protocol_error));
				end
			end
			pending = status_q.size();
		end
	end

endmodule

`default_nettype wire

[dv/serial_rtc_command_interface_core_test.sv]
// Testbench top for the serial RTC core: GPIO beat stimulus, response sink and verdict.
`timescale 1ns / 1ps
`default_nettype none

module serial_rtc_command_interface_core_test;

	localparam int         TOTAL_BEATS  = 1150;
	// ~1200 beats with random idling on both sides, taken many times over
	localparam int         CYCLE_LIMIT  = 600000;
	localparam logic       DIR_WRITE    = 1'b0;
	localparam logic       DIR_READ     = 1'b1;
	localparam logic [3:0] MAGIC        = srtc_pkg::MAGIC_NIBBLE;
	// a high nibble that is neither the magic value nor its mirror
	localparam logic [3:0] BAD_NIBBLE   = 4'b1001;

	typedef enum int {CAL_RANDOM, CAL_ZERO, CAL_ONES, CAL_TYPICAL} cal_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	srtc_pkg::cmd_beat_t cmd = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	srtc_pkg::rsp_beat_t rsp;

	int fail_count;
	int pending;
	int checked;
	int bits_driven;
	int beats_sent = 0;
	int frames_sent = 0;
	int cycles = 0;

	// steady: neither side idles while set; cal_mode shapes the calendar fields
	bit        steady = 1'b0;
	cal_mode_t cal_mode = CAL_RANDOM;

	always #5 clk = ~clk;

	serial_rtc_command_interface_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	srtc_status_checker status_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked),
		.bits_driven(bits_driven)
	);

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d status beats outstanding", cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// One GPIO write beat. Calendar fields ride along on every beat, but only
	// the beat that completes the command byte of a date or time read uses them.
	task automatic put_beat(input logic sck, input logic sio, input logic cs);
		srtc_pkg::cmd_beat_t b;
		int                  gap;
		b.year_in_century = 7'($urandom);
		b.month_number = 4'($urandom);
		b.day_of_month = 5'($urandom);
		b.weekday_number = 3'($urandom);
		b.hour_number = 5'($urandom);
		b.minute_number = 6'($urandom);
		b.second_number = 6'($urandom);
		if (cal_mode == CAL_ZERO) begin
			b = '0;
		end else if (cal_mode == CAL_ONES) begin
			b = '1;	// year 127 exercises saturation to 99
		end else if (cal_mode == CAL_TYPICAL) begin
			b.year_in_century = 7'($urandom_range(99, 0));
			b.month_number = 4'($urandom_range(12, 1));
			b.day_of_month = 5'($urandom_range(31, 1));
			b.weekday_number = 3'($urandom_range(6, 0));
			b.hour_number = 5'($urandom_range(23, 0));
			b.minute_number = 6'($urandom_range(59, 0));
			b.second_number = 6'($urandom_range(59, 0));
		end
		b.sck = sck;
		b.sio = sio;
		b.cs = cs;
		gap = steady ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= b;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		beats_sent++;
	endtask

	// Command byte as it goes on the wire, LSB first. With flip set the
	// mirrored byte is sent, which puts the magic nibble in the low bits.
	function automatic logic [7:0] code_byte(input logic [3:0] hi, input logic [2:0] code,
		input logic dir, input bit flip);
		logic [7:0] plain;
		logic [7:0] mirrored;
		plain = {hi, code, dir};
		mirrored = {<<{plain}};
		return flip ? mirrored : plain;
	endfunction

	// One framed access: start sequence, 8 command bits, nbits data bits,
	// then chip select released. glitch_at >= 0 inserts a CS-low beat ahead
	// of that command bit.
	task automatic run_frame(input logic [7:0] sent, input int nbits, input logic [63:0] data,
		input int glitch_at);
		put_beat(1'b1, 1'($urandom), 1'b0);	// start1: CS low, SCK high
		put_beat(1'b1, 1'($urandom), 1'b1);	// start2: CS and SCK high
		for (int i = 0; i < 8; i++) begin
			if (i == glitch_at)
				put_beat(1'($urandom), 1'($urandom), 1'b0);
			put_beat(1'b0, sent[i], 1'b1);
			put_beat(1'b1, 1'($urandom), 1'b1);
		end
		for (int i = 0; i < nbits; i++) begin
			put_beat(1'b0, data[i % 64], 1'b1);
			put_beat(1'b1, 1'($urandom), 1'b1);
		end
		put_beat(1'($urandom), 1'($urandom), 1'b0);
		frames_sent++;
	endtask

	// Random access, weighted toward short well-formed commands; some carry
	// a bad magic nibble, a CS glitch, an early CS drop or extra clocks.
	task automatic random_frame();
		int         pick;
		int         len;
		int         nbits;
		int         glitch_at;
		logic [2:0] code;
		logic       dir;
		logic [3:0] hi;
		bit         flip;
		pick = $urandom_range(99, 0);
		if (pick < 32)
			code = srtc_pkg::CMD_CONTROL;
		else if (pick < 48)
			code = srtc_pkg::CMD_TIME;
		else if (pick < 56)
			code = srtc_pkg::CMD_DATE;
		else if (pick < 64)
			code = srtc_pkg::CMD_RESET;
		else if (pick < 74)
			code = srtc_pkg::CMD_ALARM1;
		else if (pick < 80)
			code = srtc_pkg::CMD_ALARM2;
		else if (pick < 90)
			code = srtc_pkg::CMD_IRQ;
		else
			code = srtc_pkg::CMD_UNUSED;
		dir = 1'($urandom);
		flip = 1'($urandom);
		hi = MAGIC;
		// bad magic: mirror a byte whose nibbles both miss the magic value,
		// so the core still decodes the intended command
		if ($urandom_range(7, 0) == 0 && {code, dir} != MAGIC) begin
			do hi = 4'($urandom); while (hi == MAGIC);
			flip = 1'b1;
		end
		len = srtc_pkg::cmd_length(code);
		if (code == srtc_pkg::CMD_RESET)
			nbits = 0;
		else if (len == 0)
			nbits = (dir == DIR_READ) ? $urandom_range(70, 0) : $urandom_range(2, 0);
		else begin
			pick = $urandom_range(9, 0);
			if (pick == 0)
				nbits = $urandom_range(len - 1, 0);
			else if (pick == 1)
				nbits = len + $urandom_range(3, 1);
			else
				nbits = len;
		end
		glitch_at = ($urandom_range(7, 0) == 0) ? $urandom_range(7, 0) : -1;
		run_frame(code_byte(hi, code, dir, flip), nbits, {$urandom, $urandom}, glitch_at);
	endtask

	// Response side: random stall per beat, or none while steady
	initial begin : rsp_sink
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(13, 0);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: start-level errors, control round trips with the mask,
		// reset command, calendar extremes, every command code at least once,
		// length-0 transfers, bad magic, CS glitch and early CS drops.
		steady = 1'b1;
		put_beat(1'b0, 1'b0, 1'b0);	// start1 with SCK low: rejected
		put_beat(1'b1, 1'b1, 1'b1);	// start1 with CS high: rejected
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_READ, 1'b0), 8, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_WRITE, 1'b1), 8, 64'hFF, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_READ, 1'b1), 8, '0, -1);
		steady = 1'b0;
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_RESET, DIR_WRITE, 1'b0), 0, '0, -1);
		cal_mode = CAL_ONES;
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_DATE, DIR_READ, 1'b0), 56, '0, -1);
		cal_mode = CAL_ZERO;
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_TIME, DIR_READ, 1'b0), 24, '0, -1);
		cal_mode = CAL_TYPICAL;
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_DATE, DIR_READ, 1'b1), 56, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_TIME, DIR_READ, 1'b1), 24, '0, -1);
		cal_mode = CAL_RANDOM;
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_TIME, DIR_WRITE, 1'b0), 24, '1, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_ALARM1, DIR_READ, 1'b0), 24, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_ALARM2, DIR_WRITE, 1'b1), 24, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_IRQ, DIR_WRITE, 1'b0), 1, '0, -1);
		// length-0 read runs past the bit limit and the counter's saturation
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_UNUSED, DIR_READ, 1'b0), 70, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_IRQ, DIR_READ, 1'b1), 3, '0, -1);
		run_frame(code_byte(BAD_NIBBLE, srtc_pkg::CMD_CONTROL, DIR_WRITE, 1'b1), 8, 64'h5A, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_READ, 1'b0), 8, '0, 3);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_WRITE, 1'b0), 3, '1, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_CONTROL, DIR_WRITE, 1'b1), 8, '0, -1);
		run_frame(code_byte(MAGIC, srtc_pkg::CMD_DATE, DIR_READ, 1'b0), 10, '0, -1);

		// Random: mostly framed accesses, some loose beats between them, until
		// the beat budget is used; idling switches off for whole frames now and then
		while (beats_sent < TOTAL_BEATS) begin
			steady = ($urandom_range(4, 0) == 0);
			if ($urandom_range(5, 0) == 0)
				repeat ($urandom_range(4, 1))
					put_beat(1'($urandom), 1'($urandom), 1'($urandom));
			random_frame();
		end
		cmd_valid <= 1'b0;

		// drain: wait until every status beat is back
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d GPIO beats in %0d framed accesses plus loose beats; %0d checked.",
			beats_sent, frames_sent, checked);
		$display("Reads drove %0d bits; all commands, both bit orders, errors and idling covered.",
			bits_driven);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
